/* sv/swf_pkg.sv */
// swf_pkg: shared types, constants and reciprocal tables of the spectral window filter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package swf_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int MAX_WINDOW   = 15;
  localparam int MAX_CHANNELS = 1023;
  localparam int CNT_W        = 10;
  localparam int AGE_W        = 4;
  localparam int HALF_W       = 3;
  localparam int LOFF_W       = HALF_W + 1;
  localparam int WS_W         = 4;

  // sum and divide widths
  localparam int ACC_W        = 12;
  localparam int NUM_W        = 14;
  localparam int RECIP_W      = 19;
  localparam int RECIP_SHIFT  = 20;
  localparam int PROD_W       = NUM_W + RECIP_W;
  localparam int TAP_P_W      = 11;
  localparam int TAP_RECIP_W  = 13;
  localparam int TAP_SHIFT    = 12;

  // queue between front and back
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_MODE = 2'd1;
  localparam logic [WS_W-1:0]      WINDOW_SIZE_RESET = 4'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } swf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                last_out;
  } swf_out_t;

  // settings seen by front and back
  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic              tri_mode;
  } swf_cfg_t;

  // one classified input: sample plus the outputs it releases
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                emit;
    logic [CNT_W-1:0]    newest;
    logic [HALF_W-1:0]   j_top;
    logic [HALF_W-1:0]   j_low;
  } swf_job_t;

  function automatic logic [HALF_W-1:0] half_width(input logic [WS_W-1:0] ws);
    logic [HALF_W-1:0] h;
    h = ws[WS_W-1:1];
    if (h == '0) h = HALF_W'(1);
    return h;
  endfunction

  // floor(2^20 / (2h+1))
  function automatic logic [RECIP_W-1:0] box_recip(input logic [HALF_W-1:0] h);
    logic [RECIP_W-1:0] r;
    unique case (h)
      3'd1:    r = 19'd349525;
      3'd2:    r = 19'd209715;
      3'd3:    r = 19'd149796;
      3'd4:    r = 19'd116508;
      3'd5:    r = 19'd95325;
      3'd6:    r = 19'd80659;
      3'd7:    r = 19'd69905;
      default: r = 19'd349525;
    endcase
    return r;
  endfunction

  // floor(2^20 / (2*(3h+1)))
  function automatic logic [RECIP_W-1:0] tri_recip(input logic [HALF_W-1:0] h);
    logic [RECIP_W-1:0] r;
    unique case (h)
      3'd1:    r = 19'd131072;
      3'd2:    r = 19'd74898;
      3'd3:    r = 19'd52428;
      3'd4:    r = 19'd40329;
      3'd5:    r = 19'd32768;
      3'd6:    r = 19'd27594;
      3'd7:    r = 19'd23831;
      default: r = 19'd131072;
    endcase
    return r;
  endfunction

  // floor(2^12 / h)
  function automatic logic [TAP_RECIP_W-1:0] tap_recip(input logic [HALF_W-1:0] h);
    logic [TAP_RECIP_W-1:0] r;
    unique case (h)
      3'd1:    r = 13'd4096;
      3'd2:    r = 13'd2048;
      3'd3:    r = 13'd1365;
      3'd4:    r = 13'd1024;
      3'd5:    r = 13'd819;
      3'd6:    r = 13'd682;
      3'd7:    r = 13'd585;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/spectral_window_filter.sv */
// A sample that completes a window releases one output, h = window_size/2; the last sample of a
//   run releases up to h+1 outputs. For each output the back walks 2h+1 taps, drains the tap
//   pipeline and does a two-step reciprocal divide; it takes no new sample until its outputs
//   have been issued, and a sample with no output only shifts the history.
// Reset (rst_n low, synchronous): run counter, queue, history, output valid and the
//   configuration (window_size 3, box mode) return to their initial values.
`default_nettype none

module spectral_window_filter import swf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input samples
  input  swf_in_t               in_item,
  input  logic                  in_valid,
  output logic                  in_ready,
  // filtered channels
  output swf_out_t              out_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  // configuration writes
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  logic [WS_W-1:0] window_size_r;
  logic            triangle_mode_r;
  swf_cfg_t        cfg;
  swf_job_t        fq_job, qb_job;
  logic            fq_valid, fq_ready, qb_valid, qb_ready;

  // Config: always ready; software must write only while the filter is idle; the block does not check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_SIZE_RESET;
      triangle_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:   window_size_r   <= cfg_data[WS_W-1:0];
        CFG_TRIANGLE_MODE: triangle_mode_r <= cfg_data[0];
        default:           ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Half width h: window_size/2, never below 1.
  assign cfg.half     = half_width(window_size_r);
  assign cfg.tri_mode = triangle_mode_r;

  // Front: count the run and classify each sample transfer.
  swf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .job       (fq_job),
    .job_valid (fq_valid),
    .job_ready (fq_ready)
  );

  // Hold classified samples so the front keeps taking input while the back works, until the queue fills.
  swf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fq_job),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (qb_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready)
  );

  // Back: advance the history, walk the window taps, divide, present the result.
  swf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (qb_job),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

/* sv/swf_front.sv */
// swf_front: accepts samples, counts the run and decides which outputs each sample releases.
// Depends on swf_pkg.
`default_nettype none

module swf_front import swf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  swf_cfg_t cfg,
  input  swf_in_t  in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output swf_job_t job,
  output logic     job_valid,
  input  logic     job_ready
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] newest;
  logic             accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  always_comb begin
    // saturate the run length at the channel limit
    cnt_inc = (cnt_r == CNT_W'(MAX_CHANNELS)) ? cnt_r : cnt_r + CNT_W'(1);
    newest  = cnt_inc - CNT_W'(1);
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_item.last_sample ? '0 : cnt_inc;
    end
  end

  always_comb begin
    job.sample = in_item.sample;
    job.last   = in_item.last_sample;
    job.newest = newest;
    if (in_item.last_sample) begin
      // flush: every channel from newest-h (or the first) up to newest
      job.emit  = 1'b1;
      job.j_top = (newest < CNT_W'(cfg.half)) ? newest[HALF_W-1:0] : cfg.half;
      job.j_low = '0;
    end else begin
      job.emit  = (newest >= CNT_W'(cfg.half));
      job.j_top = cfg.half;
      job.j_low = cfg.half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/swf_queue.sv */
// swf_queue: short FIFO that decouples the front from the back.
// Depends on swf_pkg.
`default_nettype none

module swf_queue import swf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  swf_job_t push_data,
  input  logic     push_valid,
  output logic     push_ready,
  output swf_job_t pop_data,
  output logic     pop_valid,
  input  logic     pop_ready
);

  swf_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_fire, pop_fire;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue level beyond depth");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue level did not grow on push");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && (count_r == '0)) |=> (pop_data == $past(push_data)))
    else $error("queue head is not the entry pushed into an empty queue");
`endif

endmodule

`default_nettype wire

/* sv/swf_back.sv */
// swf_back: sample history, tap sequencer, weighting pipeline, window divide and output register.
// Depends on swf_pkg.
`default_nettype none

module swf_back import swf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  swf_cfg_t cfg,
  input  swf_job_t job,
  input  logic     job_valid,
  output logic     job_ready,
  output swf_out_t out_item,
  output logic     out_valid,
  input  logic     out_ready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TAP  = 6'b000010,
    S_FIN  = 6'b000100,
    S_DIV1 = 6'b001000,
    S_DIV2 = 6'b010000,
    S_EMIT = 6'b100000
  } swf_state_t;

  localparam logic signed [CNT_W+1:0] AGE_MAX_S = (CNT_W+2)'(MAX_WINDOW - 1);

  swf_state_t               state_r, state_nxt;
  logic [SAMPLE_W-1:0]      hist_r [MAX_WINDOW];
  logic [CNT_W-1:0]         newest_r;
  logic                     last_r;
  logic [HALF_W-1:0]        j_r, j_low_r;
  logic signed [LOFF_W-1:0] l_r;

  // tap pipeline
  logic                     t1_v_r, t2_v_r, t3_v_r;
  logic [SAMPLE_W-1:0]      t1_x_r;
  logic [LOFF_W-1:0]        t1_w_r;
  logic [TAP_P_W-1:0]       t2_p_r, t3_p_r, t3_est_r;
  logic [ACC_W-1:0]         acc_r;

  // divide path
  logic [NUM_W-1:0]         num_r;
  logic [PROD_W-1:0]        prod_r;
  logic [SAMPLE_W-1:0]      res_r;

  swf_out_t                 out_item_r;
  logic                     out_valid_r, out_valid_nxt;

  logic                     pop, issue, tap_done, pipe_busy, emit_fire;
  logic signed [LOFF_W-1:0] l_first, l_last;
  logic [AGE_W-1:0]         age;
  logic [HALF_W-1:0]        abs_l;
  logic [LOFF_W-1:0]        weight;
  logic [2*SAMPLE_W-1:0]    wx;
  logic [TAP_P_W-1:0]       p2;
  logic [TAP_P_W+TAP_RECIP_W-1:0] est_prod;
  logic [TAP_P_W-1:0]       tap_rem, term;
  logic [HALF_W+2:0]        a2;
  logic [NUM_W-1:0]         num;
  logic [RECIP_W-1:0]       recip;
  logic [PROD_W-RECIP_SHIFT-1:0] q_est;
  logic [HALF_W+3:0]        divisor;
  logic [NUM_W-1:0]         q_rem;
  logic [PROD_W-RECIP_SHIFT-1:0] q_fix;

  // Age in the history of the sample that window offset l of output newest-j reads.
  function automatic logic [AGE_W-1:0] tap_age(
    input logic [CNT_W-1:0]         newest,
    input logic [HALF_W-1:0]        j,
    input logic signed [LOFF_W-1:0] l,
    input logic                     end_known
  );
    logic signed [CNT_W+1:0] nw, t, a;
    nw = signed'({2'b00, newest});
    t  = nw - signed'((CNT_W+2)'(j)) + (CNT_W+2)'(l);
    if (t < 0) t = -t;
    if (end_known && (t > nw)) t = (nw <<< 1) - t;
    if (t < 0) t = '0;
    if (t > nw) t = nw;
    a = nw - t;
    if (a > AGE_MAX_S) a = AGE_MAX_S;
    return a[AGE_W-1:0];
  endfunction

  assign job_ready = (state_r == S_IDLE);
  assign pop       = job_valid && job_ready;
  assign l_first   = -signed'(LOFF_W'(cfg.half));
  assign l_last    = signed'(LOFF_W'(cfg.half));
  assign issue     = (state_r == S_TAP);
  assign tap_done  = (l_r == l_last);
  assign pipe_busy = t1_v_r || t2_v_r || t3_v_r;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (pop && job.emit) state_nxt = S_TAP;
      S_TAP:   if (tap_done) state_nxt = S_FIN;
      S_FIN:   if (!pipe_busy) state_nxt = S_DIV1;
      S_DIV1:  state_nxt = S_DIV2;
      S_DIV2:  state_nxt = S_EMIT;
      S_EMIT:  if (emit_fire) state_nxt = (j_r == j_low_r) ? S_IDLE : S_TAP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // tap fetch and triangle weight 2h - |l|
  always_comb begin
    age    = tap_age(newest_r, j_r, l_r, last_r);
    abs_l  = l_r[LOFF_W-1] ? HALF_W'(-l_r) : HALF_W'(l_r);
    weight = {cfg.half, 1'b0} - LOFF_W'(abs_l);
  end

  // triangle term floor(w*x / 2h) = floor(floor(w*x/2) / h), reciprocal plus one fix-up; box term x
  always_comb begin
    wx       = (2*SAMPLE_W)'(t1_w_r) * (2*SAMPLE_W)'(t1_x_r);
    p2       = cfg.tri_mode ? TAP_P_W'(wx >> 1) : TAP_P_W'(t1_x_r);
    est_prod = (TAP_P_W+TAP_RECIP_W)'(t2_p_r) * (TAP_P_W+TAP_RECIP_W)'(tap_recip(cfg.half));
    tap_rem  = t3_p_r - TAP_P_W'(t3_est_r * TAP_P_W'(cfg.half));
    if (cfg.tri_mode) begin
      term = t3_est_r + TAP_P_W'(tap_rem >= TAP_P_W'(cfg.half));
    end else begin
      term = t3_p_r;
    end
  end

  // window divide: box sum/(2h+1), triangle (4S + a2) / (2*a2) with a2 = 3h+1
  always_comb begin
    a2      = {1'b0, cfg.half, 1'b0} + (HALF_W+3)'(cfg.half) + (HALF_W+3)'(1);
    num     = cfg.tri_mode ? ({acc_r, 2'b00} + NUM_W'(a2)) : NUM_W'(acc_r);
    recip   = cfg.tri_mode ? tri_recip(cfg.half) : box_recip(cfg.half);
    divisor = cfg.tri_mode ? {a2, 1'b0} : (HALF_W+4)'({cfg.half, 1'b1});
    q_est   = prod_r[PROD_W-1:RECIP_SHIFT];
    q_rem   = num_r - NUM_W'(q_est * (PROD_W-RECIP_SHIFT)'(divisor));
    q_fix   = q_est + (PROD_W-RECIP_SHIFT)'(q_rem >= NUM_W'(divisor));
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit_fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      t1_v_r      <= 1'b0;
      t2_v_r      <= 1'b0;
      t3_v_r      <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) hist_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      t1_v_r      <= issue;
      t2_v_r      <= t1_v_r;
      t3_v_r      <= t2_v_r;
      if (pop) begin
        // shift in the newest sample
        hist_r[0] <= job.sample;
        for (int i = 1; i < MAX_WINDOW; i++) hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      newest_r <= job.newest;
      last_r   <= job.last;
      j_r      <= job.j_top;
      j_low_r  <= job.j_low;
      l_r      <= l_first;
      acc_r    <= '0;
    end else if (emit_fire) begin
      j_r      <= j_r - HALF_W'(1);
      l_r      <= l_first;
      acc_r    <= '0;
    end else begin
      if (issue) l_r <= l_r + LOFF_W'(1);
      if (t3_v_r) acc_r <= acc_r + ACC_W'(term);
    end
    t1_x_r   <= hist_r[age];
    t1_w_r   <= weight;
    t2_p_r   <= p2;
    t3_p_r   <= t2_p_r;
    t3_est_r <= TAP_P_W'(est_prod >> TAP_SHIFT);
    if (state_r == S_FIN) num_r <= num;
    if (state_r == S_DIV1) prod_r <= PROD_W'(num_r) * PROD_W'(recip);
    if (state_r == S_DIV2) begin
      res_r <= (q_fix > (PROD_W-RECIP_SHIFT)'(255)) ? 8'd255 : q_fix[SAMPLE_W-1:0];
    end
    if (emit_fire) begin
      out_item_r.filtered <= res_r;
      out_item_r.last_out <= last_r && (j_r == '0);
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
